/* design/tbf_pkg.sv */
// shared types, codes and helpers of the timed batch former
package tbf_pkg;

	localparam int BATCH_CAP = 16;
	localparam int IDX_W = (BATCH_CAP > 1) ? $clog2(BATCH_CAP) : 1;
	localparam int CNT_W = $clog2(BATCH_CAP + 1);
	localparam int MBS_W = 5;
	localparam int CMP_W = (CNT_W > MBS_W) ? CNT_W : MBS_W;

	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_START = 2'd1;
	localparam logic [1:0] OP_REQ   = 2'd2;

	localparam logic [1:0] ST_MEMBER  = 2'd0;
	localparam logic [1:0] ST_EMPTY   = 2'd1;
	localparam logic [1:0] ST_REFUSED = 2'd2;

	localparam logic [1:0] MODE_FIFO = 2'd0;
	localparam logic [1:0] MODE_PRIO = 2'd3;

	localparam logic [1:0] REG_POLICY  = 2'd0;
	localparam logic [1:0] REG_MAXSIZE = 2'd1;
	localparam logic [1:0] REG_MAXWAIT = 2'd2;
	localparam logic [1:0] REG_ENABLE  = 2'd3;

	typedef struct packed {
		logic [15:0] id;
		logic [2:0]  prio;
		logic [31:0] dl;
	} entry_t;

	typedef struct packed {
		logic load;
		logic take_right;
		logic take_left;
	} cell_ctl_t;

	typedef struct packed {
		logic             wr;
		logic [IDX_W-1:0] wr_idx;
		logic             shift;
		logic             sort;
		logic             par;
		logic [CNT_W-1:0] cnt;
	} chain_ctl_t;

	// true when a must be served ahead of b
	function automatic logic goes_before(entry_t a, entry_t b);
		logic r;
		if (a.prio != b.prio) begin
			r = (a.prio > b.prio);
		end else begin
			r = (a.dl < b.dl);
		end
		return r;
	endfunction

endpackage

/* design/tbf_cell.sv */
// one storage cell of the batch chain
module tbf_cell import tbf_pkg::*; (
	input  logic      clk,
	input  cell_ctl_t ctl,
	input  entry_t    new_e,
	input  entry_t    left_e,
	input  entry_t    right_e,
	output entry_t    e
);

	entry_t e_q;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			e_q <= new_e;
		end else if (ctl.take_right) begin
			e_q <= right_e;
		end else if (ctl.take_left) begin
			e_q <= left_e;
		end
	end

	assign e = e_q;

endmodule

/* design/tbf_chain.sv */
// row of cells with fill, odd-even exchange and drain toward the head
module tbf_chain import tbf_pkg::*; (
	input  logic       clk,
	input  chain_ctl_t ctl,
	input  entry_t     wr_e,
	output entry_t     head
);

	entry_t    e   [BATCH_CAP];
	logic      swp [BATCH_CAP];
	cell_ctl_t cctl[BATCH_CAP];

	// pair (i, i+1) swaps when i matches the phase parity and the right one goes first
	always_comb begin
		for (int i = 0; i < BATCH_CAP; i++) begin
			swp[i] = 1'b0;
			if (i < BATCH_CAP - 1) begin
				swp[i] = ctl.sort && (1'(i % 2) == ctl.par) &&
					(CNT_W'(i + 1) < ctl.cnt) && goes_before(e[(i + 1) % BATCH_CAP], e[i]);
			end
		end
	end

	always_comb begin
		for (int i = 0; i < BATCH_CAP; i++) begin
			cctl[i].load       = ctl.wr && (ctl.wr_idx == IDX_W'(i));
			cctl[i].take_right = ctl.shift || swp[i];
			cctl[i].take_left  = (i > 0) ? swp[(i + BATCH_CAP - 1) % BATCH_CAP] : 1'b0;
		end
	end

	for (genvar g = 0; g < BATCH_CAP; g++) begin : g_cell
		tbf_cell u_cell (
			.clk     (clk),
			.ctl     (cctl[g]),
			.new_e   (wr_e),
			.left_e  (e[(g > 0) ? g - 1 : 0]),
			.right_e (e[(g < BATCH_CAP - 1) ? g + 1 : BATCH_CAP - 1]),
			.e       (e[g])
		);
	end

	assign head = e[0];

endmodule

/* design/timed_batch_former_priority_sort.sv */
// top level of the timed batch former with priority ordering
//
// a start item (tuser op start) opens a collection window; request items join the
// batch held in a row of cells, tick items age the window by one millisecond. the
// batch closes when full, when max_wait_ms ticks have passed, or on the first
// request in fifo mode. its members then leave on the master side one result per
// cycle while m_tready allows, tlast on the final one; a batch with no members
// gives one empty-batch result. while no batch is closing, one item is taken per
// cycle whenever the output register is free, and a refused request comes back
// as one result. when a batch closes the input stalls: in priority mode with more
// than one member the cell row is sorted by odd-even compare-exchange (priority
// descending, then absolute deadline ascending, ties kept in arrival order), then
// the members drain from the head, paced by m_tready. no clearing pass follows
// reset; configuration is by apb writes at byte address 4*index.
module timed_batch_former_priority_sort import tbf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// input items
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,  // req_id, req_priority, enqueue_ms, rel_deadline_ms
	input  logic [1:0]  s_tuser,  // op
	// result items
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,  // out_id, out_priority, abs_deadline_ms
	output logic [1:0]  m_tuser,  // status
	output logic        m_tlast,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	typedef enum logic [2:0] {
		S_RUN   = 3'b001,
		S_SORT  = 3'b010,
		S_DRAIN = 3'b100
	} state_t;

	state_t st_q;

	// configuration registers
	logic [1:0]       policy_q;
	logic [MBS_W-1:0] maxsize_q;
	logic [15:0]      maxwait_q;
	logic             enable_q;

	// window state
	logic [CNT_W-1:0] cnt_q;
	logic [15:0]      elapsed_q;
	logic             collecting_q;
	logic [IDX_W-1:0] phase_q;

	// output register
	logic        ov_q;
	logic [1:0]  o_status_q;
	entry_t      o_e_q;
	logic        o_last_q;

	logic        cfg_wr;
	logic        acc;
	logic        free;
	logic        pop;
	logic        o_load;
	logic [1:0]  op;
	entry_t      req_e;
	logic [32:0] dl_sum;
	entry_t      head;
	chain_ctl_t  cctl;

	logic [CMP_W-1:0] limit;
	logic [CNT_W-1:0] cnt_inc;
	logic [15:0]      el_inc;

	// apb port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_comb begin
		case (paddr[3:2])
			REG_POLICY:  prdata = {30'd0, policy_q};
			REG_MAXSIZE: prdata = {{(32 - MBS_W){1'b0}}, maxsize_q};
			REG_MAXWAIT: prdata = {16'd0, maxwait_q};
			REG_ENABLE:  prdata = {31'd0, enable_q};
			default:     prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q  <= MODE_FIFO;
			maxsize_q <= MBS_W'(16);
			maxwait_q <= 16'd10;
			enable_q  <= 1'b1;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_POLICY:  policy_q  <= pwdata[1:0];
				REG_MAXSIZE: maxsize_q <= pwdata[MBS_W-1:0];
				REG_MAXWAIT: maxwait_q <= pwdata[15:0];
				REG_ENABLE:  enable_q  <= pwdata[0];
				default:     ;
			endcase
		end
	end

	// input unpacking, absolute deadline saturates at all ones
	assign op         = s_tuser;
	assign req_e.id   = s_tdata[15:0];
	assign req_e.prio = s_tdata[18:16];
	assign dl_sum     = {1'b0, s_tdata[50:19]} + {17'd0, s_tdata[66:51]};
	assign req_e.dl   = dl_sum[32] ? 32'hFFFF_FFFF : dl_sum[31:0];

	// output slot free this cycle
	assign free     = !ov_q || m_tready;
	assign s_tready = (st_q == S_RUN) && free;
	assign acc      = s_tvalid && s_tready;
	assign pop      = (st_q == S_DRAIN) && free;

	// batch size limit clamped to one .. BATCH_CAP
	always_comb begin
		if (maxsize_q == '0) begin
			limit = CMP_W'(1);
		end else if (CMP_W'(maxsize_q) > CMP_W'(BATCH_CAP)) begin
			limit = CMP_W'(BATCH_CAP);
		end else begin
			limit = CMP_W'(maxsize_q);
		end
	end

	assign cnt_inc = (cnt_q < CNT_W'(BATCH_CAP)) ? cnt_q + CNT_W'(1) : cnt_q;
	assign el_inc  = (elapsed_q == 16'hFFFF) ? elapsed_q : elapsed_q + 16'd1;

	// a result lands in the output register this cycle
	always_comb begin
		o_load = pop;
		if (acc) begin
			case (op)
				OP_TICK:  o_load = collecting_q && (el_inc >= maxwait_q) && (cnt_q == '0);
				OP_START: o_load = !enable_q || (!collecting_q && maxwait_q == 16'd0);
				OP_REQ:   o_load = !collecting_q || !enable_q;
				default:  o_load = 1'b0;
			endcase
		end
	end

	// chain control
	always_comb begin
		cctl.wr     = acc && (op == OP_REQ) && collecting_q && enable_q &&
			(cnt_q < CNT_W'(BATCH_CAP));
		cctl.wr_idx = cnt_q[IDX_W-1:0];
		cctl.shift  = pop;
		cctl.sort   = (st_q == S_SORT);
		cctl.par    = phase_q[0];
		cctl.cnt    = cnt_q;
	end

	tbf_chain u_chain (
		.clk  (clk),
		.ctl  (cctl),
		.wr_e (req_e),
		.head (head)
	);

	// control and window sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= S_RUN;
			cnt_q        <= '0;
			elapsed_q    <= '0;
			collecting_q <= 1'b0;
			phase_q      <= '0;
			ov_q         <= 1'b0;
			o_status_q   <= ST_MEMBER;
			o_e_q        <= '0;
			o_last_q     <= 1'b0;
		end else begin
			if (o_load) begin
				ov_q <= 1'b1;
			end else if (m_tready) begin
				ov_q <= 1'b0;
			end
			case (st_q)
				S_RUN: begin
					if (acc) begin
						case (op)
							OP_TICK: begin
								if (collecting_q) begin
									if (el_inc >= maxwait_q) begin
										// window timed out
										collecting_q <= 1'b0;
										elapsed_q    <= '0;
										phase_q      <= '0;
										if (cnt_q == '0) begin
											o_status_q <= ST_EMPTY;
											o_e_q      <= '0;
											o_last_q   <= 1'b1;
										end else if (policy_q == MODE_PRIO &&
											cnt_q > CNT_W'(1)) begin
											st_q <= S_SORT;
										end else begin
											st_q <= S_DRAIN;
										end
									end else begin
										elapsed_q <= el_inc;
									end
								end
							end
							OP_START: begin
								if (!enable_q) begin
									o_status_q <= ST_EMPTY;
									o_e_q      <= '0;
									o_last_q   <= 1'b1;
								end else if (!collecting_q) begin
									cnt_q     <= '0;
									elapsed_q <= '0;
									if (maxwait_q == 16'd0) begin
										o_status_q <= ST_EMPTY;
										o_e_q      <= '0;
										o_last_q   <= 1'b1;
									end else begin
										collecting_q <= 1'b1;
									end
								end
							end
							OP_REQ: begin
								if (!collecting_q || !enable_q) begin
									o_status_q <= ST_REFUSED;
									o_e_q      <= req_e;
									o_last_q   <= 1'b0;
								end else begin
									cnt_q <= cnt_inc;
									if (policy_q == MODE_FIFO ||
										CMP_W'(cnt_inc) >= limit) begin
										// batch closes with at least one member
										collecting_q <= 1'b0;
										elapsed_q    <= '0;
										phase_q      <= '0;
										if (policy_q == MODE_PRIO && cnt_inc > CNT_W'(1)) begin
											st_q <= S_SORT;
										end else begin
											st_q <= S_DRAIN;
										end
									end
								end
							end
							default: ;
						endcase
					end
				end
				S_SORT: begin
					phase_q <= phase_q + IDX_W'(1);
					if (phase_q == IDX_W'(BATCH_CAP - 1)) begin
						st_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					if (pop) begin
						o_status_q <= ST_MEMBER;
						o_e_q      <= head;
						o_last_q   <= (cnt_q == CNT_W'(1));
						cnt_q      <= cnt_q - CNT_W'(1);
						if (cnt_q == CNT_W'(1)) begin
							st_q <= S_RUN;
						end
					end
				end
				default: st_q <= S_RUN;
			endcase
		end
	end

	assign m_tvalid = ov_q;
	assign m_tuser  = o_status_q;
	assign m_tdata  = {5'd0, o_e_q.dl, o_e_q.prio, o_e_q.id};
	assign m_tlast  = o_last_q;

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(BATCH_CAP))
		else $error("batch count above capacity");

	a_collect_run: assert property (@(posedge clk) disable iff (!arst_n)
		collecting_q |-> (st_q == S_RUN))
		else $error("window open outside collection");

	a_drain_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_DRAIN) |-> (cnt_q != '0))
		else $error("drain with no members");

	a_last_back: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && cnt_q == CNT_W'(1)) |=> (st_q == S_RUN && m_tvalid && m_tlast))
		else $error("final member did not end the batch");
`endif

endmodule
